// ----- rtl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit heap allocator: default sizes,
// register indexes, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // default sizes
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned MAX_PAGES_DEF    = 64;
  localparam int unsigned MAX_BLOCKS_DEF   = 256;
  localparam int unsigned HEADER_BYTES_DEF = 12;

  // register reset values
  localparam logic [31:0] HEAP_BASE_RST  = 32'hE000_0000;
  localparam logic [6:0]  PAGE_LIMIT_RST = 7'd64;

  // configuration register indexes
  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_idx_e;

  // commands
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_PAGES   = 2'd1,
    STAT_BELOW_BASE = 2'd2,
    STAT_NO_BLOCK   = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [4:0] {
    FS_IDLE,
    FS_A_SCAN,
    FS_G_PREP,
    FS_GROW,
    FS_G_TAKE,
    FS_G_LINK,
    FS_S_CHK,
    FS_S_TAKE,
    FS_S_FIXN,
    FS_COMMIT,
    FS_F_SCAN,
    FS_F_PREV,
    FS_F_PREVD,
    FS_F_NEXT,
    FS_F_NEXTD,
    FS_F_NNRD,
    FS_F_TAIL,
    FS_F_SHRINK,
    FS_F_TRIM,
    FS_DONE
  } fsm_e;

  // spare slot stack controls
  typedef struct packed {
    logic take;
    logic give;
  } spare_ctl_t;

endpackage

// ----- rtl/ffa_spare_stack.sv -----
// ----------------------------------------------------------------------------
// ffa_spare_stack
// Stack of unused block slot numbers in a one-port memory. Entries never
// pushed read as their own index, so the reset order needs no fill pass.
// ----------------------------------------------------------------------------
module ffa_spare_stack #(
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
  localparam int unsigned IW = $clog2(MAX_BLOCKS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffa_pkg::spare_ctl_t ctl_i,
  input  logic [IW-1:0]       give_slot_i,
  output logic [IW:0]         count_o,
  output logic [IW-1:0]       slot_o
);

  logic [IW-1:0]         stack_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] filled_q;
  logic [IW:0]           count_q, count_d;
  logic [IW-1:0]         pop_idx, push_idx;
  logic [IW-1:0]         rd_data_q, rd_idx_q;
  logic                  rd_filled_q;

  assign pop_idx  = IW'(count_q - 1'b1);
  assign push_idx = count_q[IW-1:0];

  // fill count
  always_comb begin
    count_d = count_q;
    if (ctl_i.take) begin
      count_d = count_q - 1'b1;
    end else if (ctl_i.give) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= (IW+1)'(MAX_BLOCKS);
      filled_q <= '0;
    end else begin
      count_q <= count_d;
      if (ctl_i.give) begin
        filled_q[push_idx] <= 1'b1;
      end
    end
  end

  // memory: push write, registered pop read
  always_ff @(posedge clk_i) begin
    if (ctl_i.give) begin
      stack_mem[push_idx] <= give_slot_i;
    end
    if (ctl_i.take) begin
      rd_data_q   <= stack_mem[pop_idx];
      rd_idx_q    <= pop_idx;
      rd_filled_q <= filled_q[pop_idx];
    end
  end

  assign slot_o  = rd_filled_q ? rd_data_q : rd_idx_q;
  assign count_o = count_q;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Page-backed first-fit heap with split and coalescing; block list kept in a
// slot memory, unused slot numbers in a spare stack.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: request_length, free_address; tuser: cmd
//  m_axis    | out       | tdata: block_address, pages_mapped; tuser: status
//  cfg       | in        | cfg_index_i register index, cfg_data_i value
//
//  allocate: walk the list, grow the heap page by page, split, then commit
//  free: walk the list, merge free neighbours, then return whole pages
//  all list reads go through the single read port of the slot memory
//  reset clears the list head, heap top and spare count at once, no sweep
//  a result waits in the output register; the next item is taken meanwhile
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int unsigned PAGE_BYTES   = ffa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_PAGES    = ffa_pkg::MAX_PAGES_DEF,
  parameter int unsigned MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // request_length[18:0], free_address[50:19]
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // block_address[31:0], pages_mapped[38:32]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned NW = IW + 1;
  localparam int unsigned TW = $clog2(MAX_PAGES * PAGE_BYTES + 1);
  localparam int unsigned OW = $clog2(MAX_PAGES * PAGE_BYTES);
  localparam int unsigned PW = $clog2(MAX_PAGES + 1);
  localparam logic [NW-1:0] NIL   = NW'(MAX_BLOCKS);
  localparam logic [31:0]   HDR32 = 32'(HEADER_BYTES);
  localparam logic [31:0]   PG32  = 32'(PAGE_BYTES);

  typedef struct packed {
    logic [OW-1:0] off;
    logic [TW-1:0] len;
    logic          used;
    logic [NW-1:0] nxt;
    logic [NW-1:0] prv;
  } slot_t;

  ffa_pkg::fsm_e state_q, state_d;

  slot_t         slot_mem [MAX_BLOCKS];
  slot_t         mem_rd_q, mem_wd;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;

  logic [NW-1:0] head_q, head_d, cur_q, cur_d, rear_q, rear_d, nb_q, nb_d;
  logic [NW-1:0] nslot_q, nslot_d;
  slot_t         cur_s_q, cur_s_d, rear_s_q, rear_s_d;
  logic [TW-1:0] top_q, top_d, gtop_q, gtop_d;
  logic [PW-1:0] pages_q, pages_d, gpages_q, gpages_d;
  logic [31:0]   need_q, need_d, target_q, target_d, foff_q, foff_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   addr_q, addr_d;
  logic [31:0]   heap_base_q;
  logic [6:0]    page_limit_q;

  logic          ovalid_q, ovalid_d;
  logic [1:0]    ostatus_q, ostatus_d;
  logic [31:0]   oaddr_q, oaddr_d;
  logic [6:0]    opages_q, opages_d;

  ffa_pkg::spare_ctl_t sp_ctl;
  logic [IW-1:0] sp_give_slot, sp_slot;
  logic [IW:0]   sp_count;

  // spare slot stack
  ffa_spare_stack #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_spare (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (sp_ctl),
    .give_slot_i (sp_give_slot),
    .count_o     (sp_count),
    .slot_o      (sp_slot)
  );

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= slot_mem[mem_ra];
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= ffa_pkg::HEAP_BASE_RST;
      page_limit_q <= ffa_pkg::PAGE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ffa_pkg::CFG_HEAP_BASE) begin
        heap_base_q <= cfg_data_i;
      end else begin
        page_limit_q <= cfg_data_i[6:0];
      end
    end
  end

  // sequencer: next state, memory accesses, list updates
  always_comb begin
    slot_t       rd;
    slot_t       ns;
    logic [31:0] base32;
    logic [31:0] diff32;
    logic [31:0] lim32;
    logic [31:0] off32;
    logic [31:0] fa32;

    state_d      = state_q;
    head_d       = head_q;
    cur_d        = cur_q;
    rear_d       = rear_q;
    nb_d         = nb_q;
    nslot_d      = nslot_q;
    cur_s_d      = cur_s_q;
    rear_s_d     = rear_s_q;
    top_d        = top_q;
    gtop_d       = gtop_q;
    pages_d      = pages_q;
    gpages_d     = gpages_q;
    need_d       = need_q;
    target_d     = target_q;
    foff_d       = foff_q;
    status_d     = status_q;
    addr_d       = addr_q;
    ovalid_d     = ovalid_q;
    ostatus_d    = ostatus_q;
    oaddr_d      = oaddr_q;
    opages_d     = opages_q;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = cur_s_q;
    mem_ra       = '0;
    sp_ctl       = '0;
    sp_give_slot = cur_q[IW-1:0];
    s_axis_tready = 1'b0;

    rd     = mem_rd_q;
    ns     = cur_s_q;
    base32 = '0;
    diff32 = 32'(cur_s_q.len) - need_q;
    lim32  = (32'(page_limit_q) < 32'(MAX_PAGES)) ? 32'(page_limit_q) : 32'(MAX_PAGES);
    fa32   = s_axis_tdata[50:19];
    off32  = fa32 - heap_base_q;

    // output register drains independently
    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ffa_pkg::FS_IDLE: begin
        s_axis_tready = 1'b1;
        mem_ra = head_q[IW-1:0];
        if (s_axis_tvalid) begin
          status_d = ffa_pkg::STAT_OK;
          addr_d   = '0;
          if (s_axis_tuser[0] == ffa_pkg::CMD_ALLOC) begin
            need_d = 32'(s_axis_tdata[18:0]) + HDR32;
            cur_d  = head_q;
            rear_d = NIL;
            state_d = (head_q == NIL) ? ffa_pkg::FS_G_PREP : ffa_pkg::FS_A_SCAN;
          end else if (fa32 < heap_base_q) begin
            status_d = ffa_pkg::STAT_BELOW_BASE;
            state_d  = ffa_pkg::FS_DONE;
          end else if (off32 < HDR32 || head_q == NIL) begin
            status_d = ffa_pkg::STAT_NO_BLOCK;
            state_d  = ffa_pkg::FS_DONE;
          end else begin
            foff_d  = off32 - HDR32;
            cur_d   = head_q;
            state_d = ffa_pkg::FS_F_SCAN;
          end
        end
      end

      // first-fit walk
      ffa_pkg::FS_A_SCAN: begin
        if (!rd.used && 32'(rd.len) >= need_q) begin
          cur_s_d = rd;
          state_d = ffa_pkg::FS_S_CHK;
        end else begin
          rear_d   = cur_q;
          rear_s_d = rd;
          if (rd.nxt == NIL) begin
            state_d = ffa_pkg::FS_G_PREP;
          end else begin
            cur_d  = rd.nxt;
            mem_ra = rd.nxt[IW-1:0];
          end
        end
      end

      ffa_pkg::FS_G_PREP: begin
        if (rear_q != NIL) begin
          base32 = rear_s_q.used ? 32'(rear_s_q.off) + 32'(rear_s_q.len)
                                 : 32'(rear_s_q.off);
        end
        target_d = base32 + need_q;
        gtop_d   = top_q;
        gpages_d = pages_q;
        state_d  = ffa_pkg::FS_GROW;
      end

      // grow one page a cycle until the request fits or the page limit is reached
      ffa_pkg::FS_GROW: begin
        if (32'(gtop_q) >= target_q) begin
          if (rear_q != NIL && !rear_s_q.used) begin
            ns      = rear_s_q;
            ns.len  = TW'(gtop_q - TW'(rear_s_q.off));
            cur_d   = rear_q;
            cur_s_d = ns;
            top_d   = gtop_q;
            pages_d = gpages_q;
            state_d = ffa_pkg::FS_S_CHK;
          end else if (sp_count == '0) begin
            status_d = ffa_pkg::STAT_NO_PAGES;
            state_d  = ffa_pkg::FS_DONE;
          end else begin
            sp_ctl.take = 1'b1;
            state_d     = ffa_pkg::FS_G_TAKE;
          end
        end else if (32'(gpages_q) + 32'd1 > lim32) begin
          status_d = ffa_pkg::STAT_NO_PAGES;
          state_d  = ffa_pkg::FS_DONE;
        end else begin
          gtop_d   = gtop_q + TW'(PAGE_BYTES);
          gpages_d = gpages_q + PW'(1);
        end
      end

      // new tail block
      ffa_pkg::FS_G_TAKE: begin
        ns.off  = OW'(top_q);
        ns.len  = gtop_q - top_q;
        ns.used = 1'b0;
        ns.nxt  = NIL;
        ns.prv  = rear_q;
        mem_we  = 1'b1;
        mem_wa  = sp_slot;
        mem_wd  = ns;
        cur_d   = {1'b0, sp_slot};
        cur_s_d = ns;
        top_d   = gtop_q;
        pages_d = gpages_q;
        if (rear_q != NIL) begin
          state_d = ffa_pkg::FS_G_LINK;
        end else begin
          head_d  = {1'b0, sp_slot};
          state_d = ffa_pkg::FS_S_CHK;
        end
      end

      ffa_pkg::FS_G_LINK: begin
        ns      = rear_s_q;
        ns.nxt  = cur_q;
        mem_we  = 1'b1;
        mem_wa  = rear_q[IW-1:0];
        mem_wd  = ns;
        state_d = ffa_pkg::FS_S_CHK;
      end

      // split when more than a header remains and a spare slot is left
      ffa_pkg::FS_S_CHK: begin
        if (diff32 > HDR32 && sp_count != '0) begin
          sp_ctl.take = 1'b1;
          state_d     = ffa_pkg::FS_S_TAKE;
        end else begin
          state_d = ffa_pkg::FS_COMMIT;
        end
      end

      ffa_pkg::FS_S_TAKE: begin
        ns.off  = cur_s_q.off + OW'(need_q);
        ns.len  = cur_s_q.len - TW'(need_q);
        ns.used = 1'b0;
        ns.nxt  = cur_s_q.nxt;
        ns.prv  = cur_q;
        mem_we  = 1'b1;
        mem_wa  = sp_slot;
        mem_wd  = ns;
        nslot_d = {1'b0, sp_slot};
        nb_d    = cur_s_q.nxt;
        cur_s_d.nxt = {1'b0, sp_slot};
        cur_s_d.len = TW'(need_q);
        if (cur_s_q.nxt != NIL) begin
          mem_ra  = cur_s_q.nxt[IW-1:0];
          state_d = ffa_pkg::FS_S_FIXN;
        end else begin
          state_d = ffa_pkg::FS_COMMIT;
        end
      end

      ffa_pkg::FS_S_FIXN: begin
        ns      = rd;
        ns.prv  = nslot_q;
        mem_we  = 1'b1;
        mem_wa  = nb_q[IW-1:0];
        mem_wd  = ns;
        state_d = ffa_pkg::FS_COMMIT;
      end

      ffa_pkg::FS_COMMIT: begin
        ns.used  = 1'b1;
        mem_we   = 1'b1;
        mem_wa   = cur_q[IW-1:0];
        mem_wd   = ns;
        addr_d   = heap_base_q + 32'(cur_s_q.off) + HDR32;
        status_d = ffa_pkg::STAT_OK;
        state_d  = ffa_pkg::FS_DONE;
      end

      // walk for the block at the freed offset
      ffa_pkg::FS_F_SCAN: begin
        if (32'(rd.off) == foff_q) begin
          if (!rd.used) begin
            status_d = ffa_pkg::STAT_NO_BLOCK;
            state_d  = ffa_pkg::FS_DONE;
          end else begin
            cur_s_d      = rd;
            cur_s_d.used = 1'b0;
            state_d      = ffa_pkg::FS_F_PREV;
          end
        end else if (rd.nxt == NIL) begin
          status_d = ffa_pkg::STAT_NO_BLOCK;
          state_d  = ffa_pkg::FS_DONE;
        end else begin
          cur_d  = rd.nxt;
          mem_ra = rd.nxt[IW-1:0];
        end
      end

      ffa_pkg::FS_F_PREV: begin
        if (cur_s_q.prv != NIL) begin
          mem_ra  = cur_s_q.prv[IW-1:0];
          state_d = ffa_pkg::FS_F_PREVD;
        end else begin
          state_d = ffa_pkg::FS_F_NEXT;
        end
      end

      // merge into a free predecessor
      ffa_pkg::FS_F_PREVD: begin
        if (!rd.used) begin
          ns          = rd;
          ns.len      = rd.len + cur_s_q.len;
          ns.nxt      = cur_s_q.nxt;
          sp_ctl.give = 1'b1;
          cur_d       = cur_s_q.prv;
          cur_s_d     = ns;
        end
        state_d = ffa_pkg::FS_F_NEXT;
      end

      ffa_pkg::FS_F_NEXT: begin
        if (cur_s_q.nxt != NIL) begin
          mem_ra  = cur_s_q.nxt[IW-1:0];
          nb_d    = cur_s_q.nxt;
          state_d = ffa_pkg::FS_F_NEXTD;
        end else begin
          state_d = ffa_pkg::FS_F_TAIL;
        end
      end

      // merge a free successor, or repoint its back link
      ffa_pkg::FS_F_NEXTD: begin
        if (rd.used) begin
          ns      = rd;
          ns.prv  = cur_q;
          mem_we  = 1'b1;
          mem_wa  = nb_q[IW-1:0];
          mem_wd  = ns;
          state_d = ffa_pkg::FS_F_TAIL;
        end else begin
          cur_s_d.len  = cur_s_q.len + rd.len;
          cur_s_d.nxt  = rd.nxt;
          sp_ctl.give  = 1'b1;
          sp_give_slot = nb_q[IW-1:0];
          if (rd.nxt != NIL) begin
            mem_ra  = rd.nxt[IW-1:0];
            nb_d    = rd.nxt;
            state_d = ffa_pkg::FS_F_NNRD;
          end else begin
            state_d = ffa_pkg::FS_F_TAIL;
          end
        end
      end

      ffa_pkg::FS_F_NNRD: begin
        ns      = rd;
        ns.prv  = cur_q;
        mem_we  = 1'b1;
        mem_wa  = nb_q[IW-1:0];
        mem_wd  = ns;
        state_d = ffa_pkg::FS_F_TAIL;
      end

      ffa_pkg::FS_F_TAIL: begin
        if (cur_s_q.nxt != NIL) begin
          mem_we  = 1'b1;
          mem_wa  = cur_q[IW-1:0];
          state_d = ffa_pkg::FS_DONE;
        end else begin
          state_d = ffa_pkg::FS_F_SHRINK;
        end
      end

      // return whole pages above the last block
      ffa_pkg::FS_F_SHRINK: begin
        if (32'(cur_s_q.off) + PG32 <= 32'(top_q)) begin
          top_d   = top_q - TW'(PAGE_BYTES);
          pages_d = pages_q - PW'(1);
        end else if (32'(top_q) <= 32'(cur_s_q.off)) begin
          sp_ctl.give = 1'b1;
          if (cur_s_q.prv != NIL) begin
            mem_ra  = cur_s_q.prv[IW-1:0];
            state_d = ffa_pkg::FS_F_TRIM;
          end else begin
            head_d  = NIL;
            state_d = ffa_pkg::FS_DONE;
          end
        end else begin
          ns.len  = top_q - TW'(cur_s_q.off);
          mem_we  = 1'b1;
          mem_wa  = cur_q[IW-1:0];
          mem_wd  = ns;
          state_d = ffa_pkg::FS_DONE;
        end
      end

      ffa_pkg::FS_F_TRIM: begin
        ns      = rd;
        ns.nxt  = NIL;
        mem_we  = 1'b1;
        mem_wa  = cur_s_q.prv[IW-1:0];
        mem_wd  = ns;
        state_d = ffa_pkg::FS_DONE;
      end

      // hand the result to the output register
      ffa_pkg::FS_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d  = 1'b1;
          ostatus_d = status_q;
          oaddr_d   = (status_q == ffa_pkg::STAT_OK) ? addr_q : 32'd0;
          opages_d  = 7'(pages_q);
          state_d   = ffa_pkg::FS_IDLE;
        end
      end

      default: begin
        state_d = ffa_pkg::FS_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ffa_pkg::FS_IDLE;
      head_q   <= NIL;
      top_q    <= '0;
      pages_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      top_q    <= top_d;
      pages_q  <= pages_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rear_q    <= rear_d;
    nb_q      <= nb_d;
    nslot_q   <= nslot_d;
    cur_s_q   <= cur_s_d;
    rear_s_q  <= rear_s_d;
    gtop_q    <= gtop_d;
    gpages_q  <= gpages_d;
    need_q    <= need_d;
    target_q  <= target_d;
    foff_q    <= foff_d;
    status_q  <= status_d;
    addr_q    <= addr_d;
    ostatus_q <= ostatus_d;
    oaddr_q   <= oaddr_d;
    opages_q  <= opages_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, opages_q, oaddr_q};
  assign m_axis_tuser  = ostatus_q;

  // checks
  a_spare_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_count) <= 32'(MAX_BLOCKS))
    else $error("spare slot count above slot total");

  a_top_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) == 32'(pages_q) * PG32)
    else $error("heap top and page count disagree");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffa_pkg::FS_IDLE && head_q == NIL) |-> top_q == '0)
    else $error("empty block list with pages still mapped");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit heap allocator. A directed table and
// then mostly well-formed allocate/free traffic go through the stream ports;
// an in-bench model of the block list predicts each result, which is compared
// field by field. Both sides idle at random; one long output stall fills the
// block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PG    = 4096;
  localparam int unsigned MAXPG = 64;
  localparam int unsigned MAXBL = 256;
  localparam int unsigned HDR   = 12;
  localparam int unsigned NIL   = MAXBL;
  localparam int          N_RANDOM = 1500;

  typedef struct packed {
    ffa_pkg::status_e status;
    logic [31:0]      addr;
    logic [6:0]       pages;
  } heap_res_t;

  typedef struct {
    ffa_pkg::cmd_e cmd;
    logic [18:0]   len;
    logic [31:0]   faddr;
    logic          has_exp;
    heap_res_t     exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  first_fit_heap_allocator i_dut (.*);

  always #5 clk_i = ~clk_i;

  // model state of the heap
  int unsigned blk_off [MAXBL];
  int unsigned blk_len [MAXBL];
  bit          blk_used[MAXBL];
  int unsigned blk_nxt [MAXBL];
  int unsigned blk_prv [MAXBL];
  int unsigned head_blk, top_bytes, spare_cnt;
  int unsigned spare_stk[MAXBL];
  logic [31:0] base_reg;
  logic [6:0]  limit_reg;

  heap_res_t   expected_q[$];
  logic [31:0] live_addrs[$];
  int          mism = 0;
  bit          fail = 1'b0;
  bit          idle_on = 1'b1;
  bit          hold_sink = 1'b0;

  function automatic int unsigned pop_spare();
    if (spare_cnt == 0) return NIL;
    spare_cnt--;
    return spare_stk[spare_cnt];
  endfunction

  function automatic void push_spare(int unsigned s);
    if (spare_cnt < MAXBL) begin
      spare_stk[spare_cnt] = s;
      spare_cnt++;
    end
  endfunction

  function automatic void unlink_blk(int unsigned s);
    int unsigned p, n;
    p = blk_prv[s];
    n = blk_nxt[s];
    if (p < NIL) blk_nxt[p] = n; else head_blk = n;
    if (n < NIL) blk_prv[n] = p;
    push_spare(s);
  endfunction

  function automatic ffa_pkg::status_e heap_alloc(int unsigned need,
                                                  output logic [31:0] addr);
    int unsigned cur, rear, steps, bse, newtop, pages, lim, s, n;
    bit found;
    cur = head_blk; rear = NIL; steps = 0; found = 0; addr = '0;
    while (cur < NIL && steps < MAXBL) begin
      if (!blk_used[cur] && blk_len[cur] >= need) begin
        found = 1;
        break;
      end
      rear = cur;
      cur = blk_nxt[cur];
      steps++;
    end
    if (!found) begin
      bse = 0;
      newtop = top_bytes;
      lim = (limit_reg < MAXPG) ? limit_reg : MAXPG;
      if (rear < NIL)
        bse = blk_used[rear] ? blk_off[rear] + blk_len[rear] : blk_off[rear];
      if (bse + need > top_bytes) begin
        pages = (bse + need - top_bytes + PG - 1) / PG;
        if (top_bytes / PG + pages > lim) return ffa_pkg::STAT_NO_PAGES;
        newtop = top_bytes + pages * PG;
      end
      if (rear < NIL && !blk_used[rear]) begin
        blk_len[rear] = newtop - blk_off[rear];
        cur = rear;
      end else begin
        s = pop_spare();
        if (s >= NIL) return ffa_pkg::STAT_NO_PAGES;
        blk_off[s] = top_bytes;
        blk_len[s] = newtop - top_bytes;
        blk_used[s] = 0;
        blk_nxt[s] = NIL;
        blk_prv[s] = rear;
        if (rear < NIL) blk_nxt[rear] = s; else head_blk = s;
        cur = s;
      end
      top_bytes = newtop;
    end
    if (blk_len[cur] - need > HDR) begin
      s = pop_spare();
      if (s < NIL) begin
        n = blk_nxt[cur];
        blk_off[s] = blk_off[cur] + need;
        blk_len[s] = blk_len[cur] - need;
        blk_used[s] = 0;
        blk_nxt[s] = n;
        blk_prv[s] = cur;
        if (n < NIL) blk_prv[n] = s;
        blk_nxt[cur] = s;
        blk_len[cur] = need;
      end
    end
    blk_used[cur] = 1;
    addr = base_reg + blk_off[cur] + HDR;
    return ffa_pkg::STAT_OK;
  endfunction

  function automatic ffa_pkg::status_e heap_free(logic [31:0] a);
    int unsigned off, cur, steps, p, n;
    if (a < base_reg) return ffa_pkg::STAT_BELOW_BASE;
    off = a - base_reg;
    if (off < HDR) return ffa_pkg::STAT_NO_BLOCK;
    off -= HDR;
    cur = head_blk; steps = 0;
    while (cur < NIL && steps < MAXBL) begin
      if (blk_off[cur] == off) break;
      cur = blk_nxt[cur];
      steps++;
    end
    if (cur >= NIL || blk_off[cur] != off || !blk_used[cur]) return ffa_pkg::STAT_NO_BLOCK;
    blk_used[cur] = 0;
    p = blk_prv[cur];
    if (p < NIL && !blk_used[p]) begin
      blk_len[p] += blk_len[cur];
      unlink_blk(cur);
      cur = p;
    end
    n = blk_nxt[cur];
    if (n < NIL && !blk_used[n]) begin
      blk_len[cur] += blk_len[n];
      unlink_blk(n);
    end
    if (blk_nxt[cur] >= NIL) begin
      while (blk_off[cur] + PG <= top_bytes) top_bytes -= PG;
      if (top_bytes <= blk_off[cur]) unlink_blk(cur);
      else blk_len[cur] = top_bytes - blk_off[cur];
    end
    return ffa_pkg::STAT_OK;
  endfunction

  function automatic heap_res_t predict_heap(ffa_pkg::cmd_e cmd, logic [18:0] len,
                                             logic [31:0] fa);
    heap_res_t r;
    logic [31:0] a;
    a = '0;
    if (cmd == ffa_pkg::CMD_ALLOC) r.status = heap_alloc(int'(len) + HDR, a);
    else r.status = heap_free(fa);
    r.addr = (r.status == ffa_pkg::STAT_OK) ? a : '0;
    r.pages = 7'(top_bytes / PG);
    return r;
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  // one input transaction; the prediction is queued on acceptance
  task automatic send_req(ffa_pkg::cmd_e cmd, logic [18:0] len, logic [31:0] fa,
                          bit has_exp = 0, heap_res_t exp = '0);
    heap_res_t r;
    logic [31:0] f;
    idle_burst();
    f = (cmd == ffa_pkg::CMD_FREE) ? fa : logic'($urandom_range(1)) ? $urandom() : '0;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'd0, f, len};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = predict_heap(cmd, len, f);
    if (has_exp && r !== exp) begin
      fail = 1'b1;
      $display("table row disagrees with model: %p vs %p", exp, r);
    end
    expected_q.push_back(r);
    if (cmd == ffa_pkg::CMD_ALLOC && r.status == ffa_pkg::STAT_OK) live_addrs.push_back(r.addr);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(ffa_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == ffa_pkg::CFG_HEAP_BASE) base_reg = val; else limit_reg = val[6:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // free a random live block, or the newest one
  task automatic free_live(bit newest);
    int k;
    logic [31:0] a;
    if (live_addrs.size() == 0) begin
      send_req(ffa_pkg::CMD_FREE, 19'($urandom()), $urandom());
    end else begin
      k = newest ? live_addrs.size() - 1 : $urandom_range(live_addrs.size() - 1);
      a = live_addrs[k];
      live_addrs.delete(k);
      send_req(ffa_pkg::CMD_FREE, 19'($urandom()), a);
    end
  endtask

  task automatic random_traffic(int count);
    int unsigned pick;
    logic [18:0] len;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // mostly small, a few large
        case ($urandom_range(9))
          0: len = 19'($urandom_range(262144));
          1: len = 19'($urandom());
          2, 3: len = 19'($urandom_range(20000));
          default: len = 19'($urandom_range(600));
        endcase
        send_req(ffa_pkg::CMD_ALLOC, len, '0);
      end else if (pick < 88) begin
        free_live(0);
      end else if (pick < 93) begin
        // double free or foreign address
        send_req(ffa_pkg::CMD_FREE, 19'($urandom()),
                 base_reg + HDR + 32'($urandom_range(4 * PG)));
      end else begin
        send_req(ffa_pkg::CMD_FREE, 19'($urandom()), $urandom());
      end
    end
  endtask

  // output side: random stalls plus one requested hold-off
  always @(negedge clk_i) begin
    if (!rst_ni || hold_sink) m_axis_tready <= 1'b0;
    else m_axis_tready <= !idle_on || ($urandom_range(3) != 0);
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    heap_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = ffa_pkg::status_e'(m_axis_tuser);
      got.addr   = m_axis_tdata[31:0];
      got.pages  = m_axis_tdata[38:32];
      if (expected_q.size() == 0) begin
        fail = 1'b1;
        mism++;
        if (mism <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail = 1'b1;
          mism++;
          if (mism <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

  stim_row_t table_rows[$];

  initial begin
    stim_row_t row;
    for (int i = 0; i < MAXBL; i++) spare_stk[i] = i;
    spare_cnt = MAXBL; head_blk = NIL; top_bytes = 0;
    base_reg = ffa_pkg::HEAP_BASE_RST; limit_reg = ffa_pkg::PAGE_LIMIT_RST;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: expected written only where obvious
    table_rows = '{
      '{ffa_pkg::CMD_FREE,  19'd0,      32'h0000_0000, 1,
        '{ffa_pkg::STAT_BELOW_BASE, 32'd0, 7'd0}},
      '{ffa_pkg::CMD_FREE,  19'd0,      ffa_pkg::HEAP_BASE_RST, 1,
        '{ffa_pkg::STAT_NO_BLOCK, 32'd0, 7'd0}},
      '{ffa_pkg::CMD_ALLOC, 19'd0,      32'd0,         1,
        '{ffa_pkg::STAT_OK, ffa_pkg::HEAP_BASE_RST + 12, 7'd1}},
      '{ffa_pkg::CMD_ALLOC, 19'd262144, 32'd0,         1,
        '{ffa_pkg::STAT_NO_PAGES, 32'd0, 7'd1}},
      '{ffa_pkg::CMD_ALLOC, 19'h7FFFF,  32'd0,         1,
        '{ffa_pkg::STAT_NO_PAGES, 32'd0, 7'd1}},
      '{ffa_pkg::CMD_ALLOC, 19'd100,    32'd0,         0, '0},
      '{ffa_pkg::CMD_ALLOC, 19'd4060,   32'd0,         0, '0},
      '{ffa_pkg::CMD_ALLOC, 19'd5,      32'd0,         0, '0},
      '{ffa_pkg::CMD_FREE,  19'd0,      ffa_pkg::HEAP_BASE_RST + 12, 1,
        '{ffa_pkg::STAT_OK, 32'd0, 7'd2}},
      '{ffa_pkg::CMD_FREE,  19'd0,      ffa_pkg::HEAP_BASE_RST + 12, 1,
        '{ffa_pkg::STAT_NO_BLOCK, 32'd0, 7'd2}},
      '{ffa_pkg::CMD_FREE,  19'd0,      32'hFFFF_FFFF, 0, '0},
      '{ffa_pkg::CMD_ALLOC, 19'd200000, 32'd0,         0, '0}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_req(row.cmd, row.len, row.faddr, row.has_exp, row.exp);
    end
    while (live_addrs.size() != 0) free_live(1);
    wait_drain();

    // long output stall while input keeps coming
    fork
      begin
        hold_sink = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      random_traffic(30);
    join
    wait_drain();

    // small page limit, base near top, slot exhaustion with tiny blocks
    write_reg(ffa_pkg::CFG_PAGE_LIMIT, 7'd2);
    write_reg(ffa_pkg::CFG_HEAP_BASE, 32'hFFFF_F000);
    random_traffic(200);
    wait_drain();
    write_reg(ffa_pkg::CFG_PAGE_LIMIT, 7'd0);
    random_traffic(40);
    wait_drain();
    write_reg(ffa_pkg::CFG_PAGE_LIMIT, 7'd127);
    write_reg(ffa_pkg::CFG_HEAP_BASE, 32'd0);
    for (int i = 0; i < 300; i++) send_req(ffa_pkg::CMD_ALLOC, 19'($urandom_range(20)), '0);
    random_traffic(300);
    wait_drain();
    write_reg(ffa_pkg::CFG_HEAP_BASE, $urandom());
    write_reg(ffa_pkg::CFG_PAGE_LIMIT, 7'd64);
    random_traffic(N_RANDOM - 1070);
    idle_on = 1'b0;
    random_traffic(200);
    while (live_addrs.size() != 0) free_live(0);
    wait_drain();

    if (!fail) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
